// File: rtl/knapsack_cipher_unit_defines.svh
// ----------------------------------------------------------------------------
// knapsack_cipher_unit_defines
// Assertion macros shared by the knapsack cipher unit.
// ----------------------------------------------------------------------------
`ifndef KNAPSACK_CIPHER_UNIT_DEFINES_SVH
`define KNAPSACK_CIPHER_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define KCU_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("knapsack cipher unit: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define KCU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("knapsack cipher unit: next-cycle check failed");

`endif

// File: rtl/kcu_pkg.sv
// ----------------------------------------------------------------------------
// kcu_pkg
// Widths, codes and interface structs of the knapsack cipher unit.
// ----------------------------------------------------------------------------
package kcu_pkg;

    localparam int MAX_BITS     = 8;
    localparam int WEIGHT_WIDTH = 16;
    localparam int TABLE_DEPTH  = 8;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);

    localparam int OP_W      = 2;
    localparam int PLAIN_W   = 8;
    localparam int CIPHER_W  = 19;
    localparam int VALUE_W   = 19;
    localparam int MULT_W    = 16;
    localparam int MOD_W     = 16;
    localparam int LEN_W     = 4;
    localparam int CFG_DW    = 16;
    localparam int CFG_AW    = 2;

    // effective modulus, register value zero means 2**MOD_W
    localparam int Q_W       = MOD_W + 1;
    // signed bezout coefficient
    localparam int T_W       = Q_W + 1;
    // widest dividend: cipher times inverse
    localparam int DIV_W     = CIPHER_W + Q_W - 1;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);

    localparam int MUL_A_W   = CIPHER_W + 1;
    localparam int MUL_B_W   = T_W + 1;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;

    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_ENCRYPT = 2'd1;
    localparam logic [OP_W-1:0] OP_DECRYPT = 2'd2;

    localparam logic [CFG_AW-1:0] REG_MULTIPLIER = 2'd0;
    localparam logic [CFG_AW-1:0] REG_MODULUS    = 2'd1;
    localparam logic [CFG_AW-1:0] REG_KEY_LEN    = 2'd2;

    typedef struct packed {
        logic [MULT_W-1:0] multiplier;
        logic [Q_W-1:0]    modulus;
        logic [LEN_W-1:0]  key_len;
    } kcu_cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [IDX_W-1:0]        index;
        logic [WEIGHT_WIDTH-1:0] weight;
        logic [PLAIN_W-1:0]      plain_byte;
        logic [CIPHER_W-1:0]     cipher;
    } kcu_req_t;

    typedef struct packed {
        logic               ready;
        logic               res_valid;
        logic [VALUE_W-1:0] value;
        logic               status;
    } kcu_sts_t;

    typedef struct packed {
        logic             start;
        logic             short_div;
        logic [DIV_W-1:0] dividend;
        logic [Q_W-1:0]   divisor;
    } kcu_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [Q_W-1:0]   remainder;
    } kcu_div_rsp_t;

endpackage

// File: rtl/kcu_div.sv
// ----------------------------------------------------------------------------
// kcu_div
// Restoring shift-subtract divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kcu_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  kcu_pkg::kcu_div_req_t req,
    output kcu_pkg::kcu_div_rsp_t rsp
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [kcu_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [kcu_pkg::DIV_W-1:0]      num_reg;
    logic [kcu_pkg::DIV_W-1:0]      quo_reg;
    logic [kcu_pkg::Q_W-1:0]        rem_reg;
    logic [kcu_pkg::Q_W-1:0]        dvs_reg;

    logic [kcu_pkg::Q_W:0]          trial;
    logic [kcu_pkg::Q_W:0]          diff;
    logic                           fits;

    assign trial = {rem_reg, num_reg[kcu_pkg::DIV_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                rem_reg  <= '0;
                quo_reg  <= '0;
                dvs_reg  <= req.divisor;
                // short form: dividend fits the modulus width, skip the zero top bits
                if (req.short_div) begin
                    num_reg <= {req.dividend[kcu_pkg::Q_W-1:0],
                                {(kcu_pkg::DIV_W - kcu_pkg::Q_W){1'b0}}};
                    cnt_reg <= kcu_pkg::DIV_CNT_W'(kcu_pkg::Q_W);
                end else begin
                    num_reg <= req.dividend;
                    cnt_reg <= kcu_pkg::DIV_CNT_W'(kcu_pkg::DIV_W);
                end
            end else if (busy_reg) begin
                num_reg <= {num_reg[kcu_pkg::DIV_W-2:0], 1'b0};
                quo_reg <= {quo_reg[kcu_pkg::DIV_W-2:0], fits};
                rem_reg <= fits ? diff[kcu_pkg::Q_W-1:0] : trial[kcu_pkg::Q_W-1:0];
                cnt_reg <= cnt_reg - kcu_pkg::DIV_CNT_W'(1);
                if (cnt_reg == kcu_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// File: rtl/kcu_core.sv
// ----------------------------------------------------------------------------
// kcu_core
// Sequencer with weight table and multiplier; drives the shared divider for
// every reduction, the inverse search and the quotients of euclid's steps.
// ----------------------------------------------------------------------------
module kcu_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  kcu_pkg::kcu_cfg_t cfg,
    input  logic              start,
    input  kcu_pkg::kcu_req_t req,
    input  logic              res_ready,
    output kcu_pkg::kcu_sts_t sts
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENC_SEL,
        ST_ENC_DIV,
        ST_ENC_WAIT,
        ST_DEC_AMOD,
        ST_EU_DIV,
        ST_EU_WAIT,
        ST_EU_MUL,
        ST_EU_UPD,
        ST_EU_END,
        ST_DEC_MUL,
        ST_DEC_DIV,
        ST_DEC_WAIT,
        ST_GREEDY,
        ST_DONE
    } state_t;

    state_t                              state_reg;
    kcu_pkg::kcu_req_t                   req_reg;
    kcu_pkg::kcu_div_req_t               div_req_reg;
    kcu_pkg::kcu_div_rsp_t               div_rsp;

    logic [kcu_pkg::WEIGHT_WIDTH-1:0]    weight_mem [kcu_pkg::TABLE_DEPTH];
    logic [kcu_pkg::LEN_W-1:0]           i_reg;
    logic [kcu_pkg::VALUE_W-1:0]         acc_reg;
    logic [kcu_pkg::Q_W-1:0]             r0_reg;
    logic [kcu_pkg::Q_W-1:0]             r1_reg;
    logic [kcu_pkg::T_W-1:0]             t0_reg;
    logic [kcu_pkg::T_W-1:0]             t1_reg;
    logic [kcu_pkg::Q_W-1:0]             qt_reg;
    logic [kcu_pkg::Q_W-1:0]             s_reg;
    logic [kcu_pkg::Q_W-1:0]             c1_reg;
    logic [kcu_pkg::PROD_W-1:0]          prod_reg;
    logic [kcu_pkg::MAX_BITS-1:0]        bits_reg;
    logic [kcu_pkg::VALUE_W-1:0]         value_reg;
    logic                                status_reg;

    logic [kcu_pkg::LEN_W-1:0]           enc_pos;
    logic [kcu_pkg::LEN_W-1:0]           gr_pos;
    logic [kcu_pkg::LEN_W-1:0]           bit_pos;
    logic [kcu_pkg::IDX_W-1:0]           rd_idx;
    logic [kcu_pkg::WEIGHT_WIDTH-1:0]    w_rd;
    logic [kcu_pkg::MUL_A_W-1:0]         mul_a;
    logic [kcu_pkg::MUL_B_W-1:0]         mul_b;
    logic [kcu_pkg::PROD_W-1:0]          mul_prod;
    logic [kcu_pkg::T_W-1:0]             q_ext;
    logic [kcu_pkg::T_W-1:0]             s_wrap;
    logic [kcu_pkg::T_W-1:0]             s_fix;

    kcu_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req_reg),
        .rsp     (div_rsp)
    );

    // encrypt walks the table top down, decrypt from entry n-1 to 0
    assign enc_pos = cfg.key_len - kcu_pkg::LEN_W'(1) - i_reg;
    assign gr_pos  = i_reg - kcu_pkg::LEN_W'(1);
    assign bit_pos = cfg.key_len - i_reg;
    assign rd_idx  = (state_reg == ST_GREEDY) ? gr_pos[kcu_pkg::IDX_W-1:0]
                                              : enc_pos[kcu_pkg::IDX_W-1:0];
    assign w_rd    = weight_mem[rd_idx];

    always_comb begin
        case (state_reg)
            ST_ENC_SEL: begin
                mul_a = kcu_pkg::MUL_A_W'(cfg.multiplier);
                mul_b = kcu_pkg::MUL_B_W'(w_rd);
            end
            ST_EU_MUL: begin
                mul_a = kcu_pkg::MUL_A_W'(qt_reg);
                mul_b = {t1_reg[kcu_pkg::T_W-1], t1_reg};
            end
            default: begin
                mul_a = kcu_pkg::MUL_A_W'(req_reg.cipher);
                mul_b = kcu_pkg::MUL_B_W'(s_reg);
            end
        endcase
    end

    assign mul_prod = $signed(mul_a) * $signed(mul_b);

    // fold the coefficient into [0, q)
    assign q_ext  = kcu_pkg::T_W'(cfg.modulus);
    assign s_wrap = t0_reg[kcu_pkg::T_W-1] ? t0_reg + q_ext : t0_reg;
    assign s_fix  = (s_wrap >= q_ext) ? s_wrap - q_ext : s_wrap;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            div_req_reg.start <= 1'b0;
            value_reg         <= '0;
            status_reg        <= 1'b0;
            for (int k = 0; k < kcu_pkg::TABLE_DEPTH; k++) begin
                weight_mem[k] <= '0;
            end
        end else begin
            div_req_reg.start <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        req_reg    <= req;
                        value_reg  <= '0;
                        status_reg <= 1'b0;
                        i_reg      <= '0;
                        acc_reg    <= '0;
                        unique case (req.op)
                            kcu_pkg::OP_LOAD: begin
                                weight_mem[req.index] <= req.weight;
                                state_reg             <= ST_DONE;
                            end
                            kcu_pkg::OP_ENCRYPT: begin
                                state_reg <= ST_ENC_SEL;
                            end
                            kcu_pkg::OP_DECRYPT: begin
                                if (cfg.modulus == kcu_pkg::Q_W'(1)) begin
                                    status_reg <= 1'b1;
                                    state_reg  <= ST_DONE;
                                end else begin
                                    div_req_reg.start     <= 1'b1;
                                    div_req_reg.short_div <= 1'b1;
                                    div_req_reg.dividend  <= kcu_pkg::DIV_W'(cfg.multiplier);
                                    div_req_reg.divisor   <= cfg.modulus;
                                    state_reg             <= ST_DEC_AMOD;
                                end
                            end
                            default: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_ENC_SEL: begin
                    if (i_reg == cfg.key_len) begin
                        value_reg <= acc_reg;
                        state_reg <= ST_DONE;
                    end else if (req_reg.plain_byte[i_reg[kcu_pkg::IDX_W-1:0]]) begin
                        prod_reg  <= mul_prod;
                        state_reg <= ST_ENC_DIV;
                    end else begin
                        i_reg <= i_reg + kcu_pkg::LEN_W'(1);
                    end
                end
                ST_ENC_DIV: begin
                    div_req_reg.start     <= 1'b1;
                    div_req_reg.short_div <= 1'b0;
                    div_req_reg.dividend  <= prod_reg[kcu_pkg::DIV_W-1:0];
                    div_req_reg.divisor   <= cfg.modulus;
                    state_reg             <= ST_ENC_WAIT;
                end
                ST_ENC_WAIT: begin
                    if (div_rsp.done) begin
                        acc_reg   <= acc_reg + kcu_pkg::VALUE_W'(div_rsp.remainder);
                        i_reg     <= i_reg + kcu_pkg::LEN_W'(1);
                        state_reg <= ST_ENC_SEL;
                    end
                end
                ST_DEC_AMOD: begin
                    if (div_rsp.done) begin
                        if (div_rsp.remainder == '0) begin
                            status_reg <= 1'b1;
                            state_reg  <= ST_DONE;
                        end else begin
                            r0_reg    <= cfg.modulus;
                            r1_reg    <= div_rsp.remainder;
                            t0_reg    <= '0;
                            t1_reg    <= kcu_pkg::T_W'(1);
                            state_reg <= ST_EU_DIV;
                        end
                    end
                end
                ST_EU_DIV: begin
                    div_req_reg.start     <= 1'b1;
                    div_req_reg.short_div <= 1'b1;
                    div_req_reg.dividend  <= kcu_pkg::DIV_W'(r0_reg);
                    div_req_reg.divisor   <= r1_reg;
                    state_reg             <= ST_EU_WAIT;
                end
                ST_EU_WAIT: begin
                    if (div_rsp.done) begin
                        qt_reg    <= div_rsp.quotient[kcu_pkg::Q_W-1:0];
                        r0_reg    <= r1_reg;
                        r1_reg    <= div_rsp.remainder;
                        state_reg <= ST_EU_MUL;
                    end
                end
                ST_EU_MUL: begin
                    prod_reg  <= mul_prod;
                    state_reg <= ST_EU_UPD;
                end
                ST_EU_UPD: begin
                    // the true coefficient fits, so the low bits of the product suffice
                    t0_reg    <= t1_reg;
                    t1_reg    <= t0_reg - prod_reg[kcu_pkg::T_W-1:0];
                    state_reg <= (r1_reg == '0) ? ST_EU_END : ST_EU_DIV;
                end
                ST_EU_END: begin
                    if (r0_reg != kcu_pkg::Q_W'(1)) begin
                        status_reg <= 1'b1;
                        state_reg  <= ST_DONE;
                    end else begin
                        s_reg     <= s_fix[kcu_pkg::Q_W-1:0];
                        state_reg <= ST_DEC_MUL;
                    end
                end
                ST_DEC_MUL: begin
                    prod_reg  <= mul_prod;
                    state_reg <= ST_DEC_DIV;
                end
                ST_DEC_DIV: begin
                    div_req_reg.start     <= 1'b1;
                    div_req_reg.short_div <= 1'b0;
                    div_req_reg.dividend  <= prod_reg[kcu_pkg::DIV_W-1:0];
                    div_req_reg.divisor   <= cfg.modulus;
                    state_reg             <= ST_DEC_WAIT;
                end
                ST_DEC_WAIT: begin
                    if (div_rsp.done) begin
                        c1_reg    <= div_rsp.remainder;
                        bits_reg  <= '0;
                        i_reg     <= cfg.key_len;
                        state_reg <= ST_GREEDY;
                    end
                end
                ST_GREEDY: begin
                    if (i_reg == '0) begin
                        value_reg <= kcu_pkg::VALUE_W'(bits_reg);
                        state_reg <= ST_DONE;
                    end else begin
                        if (kcu_pkg::Q_W'(w_rd) <= c1_reg) begin
                            bits_reg[bit_pos[kcu_pkg::IDX_W-1:0]] <= 1'b1;
                            c1_reg <= c1_reg - kcu_pkg::Q_W'(w_rd);
                        end
                        i_reg <= gr_pos;
                    end
                end
                ST_DONE: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign sts.ready     = (state_reg == ST_IDLE);
    assign sts.res_valid = (state_reg == ST_DONE);
    assign sts.value     = value_reg;
    assign sts.status    = status_reg;

endmodule

// File: rtl/knapsack_cipher_unit.sv
// ----------------------------------------------------------------------------
// knapsack_cipher_unit
// Knapsack cipher engine: takes one item at a time and returns one result
// beat per item. A load goes straight to the result. An encrypt is paced
// by the bit-serial divider, which reduces the product of each set
// plaintext bit within key_len by the modulus. A decrypt runs the extended
// euclid inverse on the same divider, one division per euclid step, then
// one 35-bit reduction and a greedy pass of one key bit per cycle; a
// missing inverse ends the item early. The next item is accepted as soon
// as the result has moved into the output register, even while that beat
// still waits.
// ----------------------------------------------------------------------------
`include "knapsack_cipher_unit_defines.svh"

module knapsack_cipher_unit (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic [kcu_pkg::CFG_AW-1:0]        cfg_addr,
    input  logic [kcu_pkg::CFG_DW-1:0]        cfg_wdata,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [kcu_pkg::OP_W-1:0]          s_op,
    input  logic [kcu_pkg::IDX_W-1:0]         s_index,
    input  logic [kcu_pkg::WEIGHT_WIDTH-1:0]  s_weight,
    input  logic [kcu_pkg::PLAIN_W-1:0]       s_plain_byte,
    input  logic [kcu_pkg::CIPHER_W-1:0]      s_cipher,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [kcu_pkg::VALUE_W-1:0]       m_value,
    output logic                              m_status
);

    logic [kcu_pkg::MULT_W-1:0]   multiplier_reg;
    logic [kcu_pkg::MOD_W-1:0]    modulus_reg;
    logic [kcu_pkg::LEN_W-1:0]    key_len_reg;

    logic                         m_valid_reg;
    logic [kcu_pkg::VALUE_W-1:0]  m_value_reg;
    logic                         m_status_reg;

    kcu_pkg::kcu_cfg_t            core_cfg;
    kcu_pkg::kcu_req_t            core_req;
    kcu_pkg::kcu_sts_t            core_sts;
    logic                         res_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            multiplier_reg <= kcu_pkg::MULT_W'(1);
            modulus_reg    <= '1;
            key_len_reg    <= kcu_pkg::LEN_W'(kcu_pkg::MAX_BITS);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                kcu_pkg::REG_MULTIPLIER: multiplier_reg <= cfg_wdata[kcu_pkg::MULT_W-1:0];
                kcu_pkg::REG_MODULUS:    modulus_reg    <= cfg_wdata[kcu_pkg::MOD_W-1:0];
                kcu_pkg::REG_KEY_LEN:    key_len_reg    <= cfg_wdata[kcu_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // modulus zero stands for 2**16, key length saturates at the table size
    assign core_cfg.multiplier = multiplier_reg;
    assign core_cfg.modulus    = (modulus_reg == '0) ? {1'b1, {kcu_pkg::MOD_W{1'b0}}}
                                                     : {1'b0, modulus_reg};
    assign core_cfg.key_len    = (key_len_reg > kcu_pkg::LEN_W'(kcu_pkg::MAX_BITS))
                                 ? kcu_pkg::LEN_W'(kcu_pkg::MAX_BITS) : key_len_reg;

    assign core_req.op         = s_op;
    assign core_req.index      = s_index;
    assign core_req.weight     = s_weight;
    assign core_req.plain_byte = s_plain_byte;
    assign core_req.cipher     = s_cipher;

    assign s_ready   = core_sts.ready;
    assign res_ready = !m_valid_reg || m_ready;

    kcu_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (core_cfg),
        .start     (s_valid && s_ready),
        .req       (core_req),
        .res_ready (res_ready),
        .sts       (core_sts)
    );

    // output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (core_sts.res_valid && res_ready) begin
            m_valid_reg  <= 1'b1;
            m_value_reg  <= core_sts.value;
            m_status_reg <= core_sts.status;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;
    assign m_status = m_status_reg;

    `KCU_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    `KCU_ASSERT_SAME(a_fail_has_zero_value, m_valid && m_status, m_value == '0)
    `KCU_ASSERT_NEXT(a_result_held_in_core, core_sts.res_valid && !res_ready, core_sts.res_valid && $stable(core_sts.value))

endmodule
